// ===== rtl/core/sit_pkg.sv =====
// shared types and constants for the sorted id table insert block
// no dependencies
package sit_pkg;

    localparam int ID_W   = 16;
    localparam int ADDR_W = 24;
    localparam int SLOT_W = 7;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } sit_state_t;

    typedef struct packed {
        logic cmp;
        logic shift;
    } sit_cmd_t;

    typedef struct packed {
        logic cmp;
        logic shift;
        logic load;
    } sit_cell_ctl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } sit_flag_t;

endpackage

// ===== rtl/core/sit_cell.sv =====
// one table cell: holds an id and load address, compares against the key
// and takes its lower neighbor's entry on a shift; depends on sit_pkg
module sit_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sit_pkg::sit_cell_ctl_t  ctl,
    input  logic [15:0]             key,
    input  logic [23:0]             new_addr,
    input  logic [15:0]             prev_id,
    input  logic [23:0]             prev_addr,
    output logic [15:0]             id,
    output logic [23:0]             addr,
    output sit_pkg::sit_flag_t      flag
);
    import sit_pkg::*;

    logic [ID_W-1:0]   id_reg;
    logic [ADDR_W-1:0] addr_reg;
    sit_flag_t         flag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg   <= key;
            addr_reg <= new_addr;
        end
        else if (ctl.shift)
        begin
            id_reg   <= prev_id;
            addr_reg <= prev_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
        end
        else if (ctl.cmp)
        begin
            flag_reg.lt <= (id_reg < key);
            flag_reg.eq <= (id_reg == key);
        end
    end

    assign id   = id_reg;
    assign addr = addr_reg;
    assign flag = flag_reg;

endmodule

// ===== rtl/core/sit_ctrl.sv =====
// sequencer: probe-order binary search over cell flags, insert command,
// load pointer and result register; depends on sit_pkg
module sit_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,
    input  logic [TABLE_DEPTH-1:0]            lt_vec,
    input  logic [TABLE_DEPTH-1:0]            eq_vec,
    output sit_pkg::sit_cmd_t                 cmd,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  slot,
    output logic [15:0]                       key,
    output logic [23:0]                       new_addr
);
    import sit_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    sit_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hp_reg, hp_next;
    logic [CW-1:0]     slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic              full_reg, full_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]  odata_reg, odata_next;
    logic [CW-1:0]     diff;
    logic [CW-1:0]     mid;
    logic [IW-1:0]     mid_idx;
    logic [SLOT_W-1:0] slot_out;

    assign diff     = hp_reg - lo_reg - CW'(1);
    assign mid      = lo_reg + (diff >> 1);
    assign mid_idx  = mid[IW-1:0];
    assign slot_out = SLOT_W'(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hp_reg    <= hp_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
        full_reg  <= full_next;
        key_reg   <= key_next;
        size_reg  <= size_next;
        addr_reg  <= addr_next;
        odata_reg <= odata_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hp_next     = hp_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        full_next   = full_reg;
        ptr_next    = ptr_reg;
        key_next    = key_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        cmd         = '0;
        s_tready    = 1'b0;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    key_next  = s_tdata[15:0];
                    size_next = s_tdata[39:16];
                    addr_next = ptr_reg;
                    lo_next   = '0;
                    hp_next   = count_reg;
                    hit_next  = 1'b0;
                    if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        full_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        full_next  = 1'b0;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (lo_reg < hp_reg)
                begin
                    if (eq_vec[mid_idx])
                    begin
                        slot_next  = mid;
                        hit_next   = 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else if (lt_vec[mid_idx])
                    begin
                        lo_next = mid + CW'(1);
                    end
                    else
                    begin
                        hp_next = mid;
                    end
                end
                else
                begin
                    slot_next  = lo_reg;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                count_next = count_reg + CW'(1);
                ptr_next   = ptr_reg + size_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    if (full_reg)
                    begin
                        odata_next = {7'd0, 1'b1, 1'b0, 24'd0, 7'd0};
                    end
                    else
                    begin
                        odata_next = {7'd0, 1'b0, hit_reg, addr_reg, slot_out};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign slot     = slot_reg;
    assign key      = key_reg;
    assign new_addr = addr_reg;

endmodule

// ===== rtl/core/sorted_id_table_insert.sv =====
// top level of the sorted id table insert block: a chain of id/address cells
// driven by sit_ctrl; depends on sit_pkg, sit_cell, sit_ctrl
// sequence: ST_CMP, ST_SEARCH for p search probes, p at most clog2(TABLE_DEPTH)
//   (a matching id ends it early), ST_SHIFT, ST_DONE; a full table skips to ST_DONE
// throughput: one item in work at a time, next item taken in ST_IDLE once the result
//   is registered; a result held by m_tready holds off the next result too
module sorted_id_table_insert #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // new_id[15:0], block_size[39:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // slot[6:0], load_addr[30:7], matched[31],
                                   // table_full[32], zero[39:33]
);
    import sit_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    sit_cmd_t                cmd;
    logic [CW-1:0]           slot;
    logic [ID_W-1:0]         key;
    logic [ADDR_W-1:0]       new_addr;
    logic [TABLE_DEPTH-1:0]  lt_vec;
    logic [TABLE_DEPTH-1:0]  eq_vec;
    logic [ID_W-1:0]         id_arr   [TABLE_DEPTH];
    logic [ADDR_W-1:0]       addr_arr [TABLE_DEPTH];

    sit_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .lt_vec   (lt_vec),
        .eq_vec   (eq_vec),
        .cmd      (cmd),
        .slot     (slot),
        .key      (key),
        .new_addr (new_addr)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        sit_cell_ctl_t ctl;
        sit_flag_t     flag;
        logic [ID_W-1:0]   prev_id;
        logic [ADDR_W-1:0] prev_addr;

        assign ctl.cmp   = cmd.cmp;
        assign ctl.shift = cmd.shift && (CW'(i) > slot);
        assign ctl.load  = cmd.shift && (CW'(i) == slot);

        if (i == 0)
        begin : g_first
            assign prev_id   = key;
            assign prev_addr = new_addr;
        end
        else
        begin : g_rest
            assign prev_id   = id_arr[i-1];
            assign prev_addr = addr_arr[i-1];
        end

        sit_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .key       (key),
            .new_addr  (new_addr),
            .prev_id   (prev_id),
            .prev_addr (prev_addr),
            .id        (id_arr[i]),
            .addr      (addr_arr[i]),
            .flag      (flag)
        );

        assign lt_vec[i] = flag.lt;
        assign eq_vec[i] = flag.eq;
    end

endmodule

// ===== rtl/core/sit_checker.sv =====
// port-level checks for sorted_id_table_insert, attached by bind
// depends on sorted_id_table_insert ports only
module sit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
        else $error("dropped item carries nonzero fields");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:33] == 7'd0))
        else $error("padding bits of result not zero");

    a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a busy cycle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind sorted_id_table_insert sit_checker u_sit_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_sorted_id_table_insert.sv =====
`timescale 1ns / 1ps
// self-checking bench for sorted_id_table_insert: predicts slot, load address and
// flags for every registered block and checks each result in order
// depends on sit_pkg and the sorted_id_table_insert rtl
module tb_sorted_id_table_insert;

    import sit_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int N_ITEMS      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] load_addr;
        logic              matched;
        logic              table_full;
    } placement_t;

    class insert_scoreboard;
        logic [ID_W-1:0]   id_copy   [TABLE_DEPTH];
        logic [ADDR_W-1:0] addr_copy [TABLE_DEPTH];
        int                entries;
        logic [ADDR_W-1:0] load_ptr;
        placement_t        placements_due [$];
        int                errors;
        int                inserts;
        int                dup_inserts;
        int                drops;
        int                wraps;

        function new();
            entries     = 0;
            load_ptr    = '0;
            errors      = 0;
            inserts     = 0;
            dup_inserts = 0;
            drops       = 0;
            wraps       = 0;
        endfunction

        // binary search with midpoint probes, stops on the first equal id met
        function void register_block(logic [IN_W-1:0] data);
            logic [ID_W-1:0]   key;
            logic [ADDR_W-1:0] size;
            logic [ADDR_W:0]   sum;
            placement_t        exp;
            int                lo;
            int                hi;
            int                mid;
            int                pos;
            int                i;
            key            = data[ID_W-1:0];
            size           = data[ID_W+ADDR_W-1:ID_W];
            exp.slot       = '0;
            exp.load_addr  = '0;
            exp.matched    = 1'b0;
            exp.table_full = 1'b0;
            if (entries >= TABLE_DEPTH)
            begin
                exp.table_full = 1'b1;
                drops++;
            end
            else
            begin
                lo  = 0;
                hi  = entries - 1;
                mid = 0;
                while (lo <= hi && !exp.matched)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (id_copy[mid] == key)
                        exp.matched = 1'b1;
                    else if (id_copy[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                pos = exp.matched ? mid : lo;
                if (pos > entries)
                    pos = entries;
                for (i = entries; i > pos; i--)
                begin
                    id_copy[i]   = id_copy[i-1];
                    addr_copy[i] = addr_copy[i-1];
                end
                id_copy[pos]   = key;
                addr_copy[pos] = load_ptr;
                exp.slot       = pos[SLOT_W-1:0];
                exp.load_addr  = load_ptr;
                sum            = {1'b0, load_ptr} + {1'b0, size};
                if (sum[ADDR_W])
                    wraps++;
                load_ptr = sum[ADDR_W-1:0];
                entries++;
                inserts++;
                if (exp.matched)
                    dup_inserts++;
            end
            placements_due.push_back(exp);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_placement(logic [OUT_W-1:0] data);
            placement_t exp;
            if (placements_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result %h with no item outstanding", $time, data);
                return;
            end
            exp = placements_due.pop_front();
            compare("slot", 32'(exp.slot), 32'(data[6:0]));
            compare("load_addr", 32'(exp.load_addr), 32'(data[30:7]));
            compare("matched", 32'(exp.matched), 32'(data[31]));
            compare("table_full", 32'(exp.table_full), 32'(data[32]));
            compare("pad", 32'd0, 32'(data[39:33]));
        endfunction
    endclass

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;    // new_id[15:0], block_size[39:16]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // slot, load_addr, matched, table_full, pad

    insert_scoreboard  board = new();
    int                cycles    = 0;
    int                sent      = 0;
    int                rx_cycle  = 0;
    bit                hold_req  = 1'b0;
    bit                tx_calm   = 1'b0;
    bit                rx_calm   = 1'b0;

    sorted_id_table_insert #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.register_block(s_tdata);
            if (m_tvalid && m_tready)
                board.check_placement(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return ID_W'($urandom_range(0, 16'hFFFF));
        else if (r < 7)
            return ID_W'($urandom_range(16'h7FF0, 16'h8010));
        else if (r < 8)
            return ID_W'($urandom_range(0, 7));
        else if (r < 9)
            return ID_W'($urandom_range(16'hFFF8, 16'hFFFF));
        else
            return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return ADDR_W'($urandom_range(0, 24'hFFFFFF));
        else if (r < 8)
            return ADDR_W'($urandom_range(0, 15));
        else if (r < 9)
            return ADDR_W'($urandom_range(24'hFFFFF0, 24'hFFFFFF));
        else
            return ADDR_W'($urandom_range(24'h7FFFF0, 24'h800010));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [ID_W-1:0] key, input logic [ADDR_W-1:0] size);
        int gap;
        s_tdata  <= {size, key};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 100 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_calm)
                m_tready <= 1'b1;
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, duplicates at min, max and middle, pointer wrap
        send_item(16'h8000, 24'hFFFFFF);
        send_item(16'h0000, 24'h000001);
        send_item(16'hFFFF, 24'h000000);
        send_item(16'h8000, 24'h123456);
        send_item(16'h8000, 24'h000000);
        send_item(16'h0000, 24'hFFFFFF);
        send_item(16'hFFFF, 24'h800000);
        send_item(16'h7FFF, 24'h7FFFFF);
        send_item(16'h8001, 24'h000002);
        send_item(16'h5555, 24'hAAAAAA);
        send_item(16'hAAAA, 24'h555555);
        send_item(16'h0001, 24'hFFFFFE);
        send_item(16'hFFFE, 24'h000010);
        send_item(16'h4000, 24'h000000);
        send_item(16'h3FFF, 24'hFFFFFF);
        send_item(16'hC000, 24'h000100);

        // receiver holds off while items keep coming back to back
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        repeat (12) send_item(rand_id(), rand_size());
        tx_calm  = 1'b0;

        while (sent < N_ITEMS)
        begin
            if (sent % 32 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (sent == 200)
            begin
                hold_req = 1'b1;
                tx_calm  = 1'b1;
            end
            send_item(rand_id(), rand_size());
        end
        s_tvalid <= 1'b0;

        while (board.placements_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d inserts (%0d onto an existing id, %0d load pointer wraps)",
                 board.inserts, board.dup_inserts, board.wraps);
        $display("and %0d drops on a full table; %0d mismatches over %0d items",
                 board.drops, board.errors, sent);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
